### hdl/ihb_pkg.sv
// Shared types and constants for the intensity histogram binner.
package ihb_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int SCALE_BITS     = 24;
  localparam int FRAC_BITS      = 16;
  localparam int NUMBINS_BITS   = 9;
  localparam int INDEX_BITS     = 8;
  localparam int OUT_COUNT_BITS = 32;
  localparam int SUM_BITS       = 48;
  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_INDEX_BITS = 2;

  localparam int MAX_BINS_DEF   = 256;
  localparam int COUNT_BITS_DEF = 32;

  localparam logic [SAMPLE_BITS-1:0]  RANGE_MIN_RST = '0;
  localparam logic [SCALE_BITS-1:0]   BIN_SCALE_RST = SCALE_BITS'(256);
  localparam logic [NUMBINS_BITS-1:0] NUM_BINS_RST  = NUMBINS_BITS'(256);

  typedef enum logic [1:0] {
    ACT_COUNT = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_RANGE_MIN = 2'd0,
    CFG_BIN_SCALE = 2'd1,
    CFG_NUM_BINS  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    action_t                action;
    logic [SAMPLE_BITS-1:0] sample_value;
    logic [INDEX_BITS-1:0]  bin_index;
  } item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]     bin_selected;
    logic [OUT_COUNT_BITS-1:0] bin_count;
    logic [OUT_COUNT_BITS-1:0] max_count;
    logic [OUT_COUNT_BITS-1:0] samples_seen;
    logic [SUM_BITS-1:0]       value_sum;
  } result_t;

endpackage

### hdl/intensity_histogram_binner.sv
// Equal-width histogram binner: bin mapping, bin count store and running totals.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------------
//   cfg      | cfg_we                     | cfg_index, cfg_data
//   item     | item_valid / item_ready    | item (action, value, bin index)
//   result   | result_valid / result_ready| result (bin, count, totals)
//
// One item per cycle sustained unless result_ready holds back a waiting result.
// Stages: input register (bin math, store read), read-data register (update,
// store write), result register. A count that hits the bin just being written
// is forwarded into the read-data register.
// Reset loads config defaults and clears totals and all bin valid marks; no clearing pass.
// Stalls move back stage by stage; item_ready drops only when all stages are full.
module intensity_histogram_binner #(
  parameter int MAX_BINS   = ihb_pkg::MAX_BINS_DEF,
  parameter int COUNT_BITS = ihb_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ihb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [ihb_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  ihb_pkg::item_t                      item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output ihb_pkg::result_t                    result
);

  localparam int AW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int NBW = $clog2(MAX_BINS + 1);
  localparam int NW  = (NBW > ihb_pkg::NUMBINS_BITS) ? NBW : ihb_pkg::NUMBINS_BITS;
  localparam int SB  = ihb_pkg::SAMPLE_BITS;
  localparam int PW  = ihb_pkg::SAMPLE_BITS + ihb_pkg::SCALE_BITS;
  localparam int QW  = PW - ihb_pkg::FRAC_BITS;
  localparam int IW  = ihb_pkg::INDEX_BITS;
  localparam int OCW = ihb_pkg::OUT_COUNT_BITS;
  localparam int SW  = ihb_pkg::SUM_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // configuration
  logic [SB-1:0]                        range_min;
  logic [ihb_pkg::SCALE_BITS-1:0]       bin_scale;
  logic [ihb_pkg::NUMBINS_BITS-1:0]     num_bins;
  logic [NW-1:0]                        nb_lim;
  logic [NW-1:0]                        last_bin;

  // stage 0: input register
  logic                                 r0_valid;
  ihb_pkg::item_t                       r0_item;
  logic [SB-1:0]                        r0_diff;
  logic [PW-1:0]                        r0_prod;
  logic [QW-1:0]                        r0_q;
  logic [QW-1:0]                        r0_qc;
  logic [AW-1:0]                        r0_addr;
  logic [IW-1:0]                        r0_sel;
  logic                                 r0_in_range;

  // stage 1: read-data register
  logic                                 s1_valid;
  ihb_pkg::action_t                     s1_action;
  logic [AW-1:0]                        s1_addr;
  logic [IW-1:0]                        s1_sel;
  logic                                 s1_in_range;
  logic [SB-1:0]                        s1_sample;
  logic [COUNT_BITS-1:0]                s1_rdata;
  logic [COUNT_BITS-1:0]                held;
  logic [COUNT_BITS-1:0]                inc;

  // totals and store
  logic [COUNT_BITS-1:0]                bin_mem [MAX_BINS];
  logic [MAX_BINS-1:0]                  bin_valid;
  logic [COUNT_BITS-1:0]                largest_count;
  logic [COUNT_BITS-1:0]                sample_total;
  logic [SW-1:0]                        running_sum;
  logic [COUNT_BITS-1:0]                largest_next;
  logic [COUNT_BITS-1:0]                total_next;
  logic [SW:0]                          sum_wide;
  logic [SW-1:0]                        sum_next;
  ihb_pkg::result_t                     result_next;

  // handshake
  logic                                 out_free;
  logic                                 s1_free;
  logic                                 s1_fire;
  logic                                 r0_fire;
  logic                                 item_take;
  logic                                 fwd;

  assign out_free   = !result_valid || result_ready;
  assign s1_free    = !s1_valid || out_free;
  assign item_ready = !r0_valid || s1_free;
  assign s1_fire    = s1_valid && out_free;
  assign r0_fire    = r0_valid && s1_free;
  assign item_take  = item_valid && item_ready;

  always_comb begin
    nb_lim = NW'(num_bins);
    if (num_bins == '0) begin
      nb_lim = NW'(1);
    end else if (NW'(num_bins) > NW'(MAX_BINS)) begin
      nb_lim = NW'(MAX_BINS);
    end
    last_bin = nb_lim - NW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min <= ihb_pkg::RANGE_MIN_RST;
      bin_scale <= ihb_pkg::BIN_SCALE_RST;
      num_bins  <= ihb_pkg::NUM_BINS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ihb_pkg::CFG_RANGE_MIN: range_min <= cfg_data[SB-1:0];
        ihb_pkg::CFG_BIN_SCALE: bin_scale <= cfg_data[ihb_pkg::SCALE_BITS-1:0];
        ihb_pkg::CFG_NUM_BINS:  num_bins  <= cfg_data[ihb_pkg::NUMBINS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // bin mapping
  always_comb begin
    r0_diff = r0_item.sample_value - range_min;
    r0_prod = PW'(r0_diff) * PW'(bin_scale);
    r0_q    = r0_prod[PW-1:ihb_pkg::FRAC_BITS];
    if (r0_item.sample_value < range_min) begin
      r0_q = '0;
    end
    r0_qc = (r0_q >= QW'(nb_lim)) ? QW'(last_bin) : r0_q;
    r0_in_range = NW'(r0_item.bin_index) < nb_lim;
    if (r0_item.action == ihb_pkg::ACT_READ) begin
      r0_addr = AW'(r0_item.bin_index);
      r0_sel  = r0_item.bin_index;
    end else begin
      r0_addr = AW'(r0_qc);
      r0_sel  = r0_qc[IW-1:0];
    end
  end

  assign fwd = s1_fire && (s1_action == ihb_pkg::ACT_COUNT) && (s1_addr == r0_addr);

  // count update
  always_comb begin
    held         = bin_valid[s1_addr] ? s1_rdata : '0;
    inc          = (held == CNT_MAX) ? held : held + COUNT_BITS'(1);
    largest_next = (inc > largest_count) ? inc : largest_count;
    total_next   = (sample_total == CNT_MAX) ? sample_total
                                             : sample_total + COUNT_BITS'(1);
    sum_wide     = {1'b0, running_sum} + (SW + 1)'(s1_sample);
    sum_next     = sum_wide[SW] ? '1 : sum_wide[SW-1:0];
  end

  always_comb begin
    result_next.bin_selected = '0;
    result_next.bin_count    = '0;
    result_next.max_count    = OCW'(largest_count);
    result_next.samples_seen = OCW'(sample_total);
    result_next.value_sum    = running_sum;
    case (s1_action)
      ihb_pkg::ACT_COUNT: begin
        result_next.bin_selected = s1_sel;
        result_next.bin_count    = OCW'(inc);
        result_next.max_count    = OCW'(largest_next);
        result_next.samples_seen = OCW'(total_next);
        result_next.value_sum    = sum_next;
      end
      ihb_pkg::ACT_READ: begin
        result_next.bin_selected = s1_sel;
        result_next.bin_count    = s1_in_range ? OCW'(held) : '0;
      end
      ihb_pkg::ACT_CLEAR: begin
        result_next.max_count    = '0;
        result_next.samples_seen = '0;
        result_next.value_sum    = '0;
      end
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      r0_valid      <= 1'b0;
      s1_valid      <= 1'b0;
      result_valid  <= 1'b0;
      bin_valid     <= '0;
      largest_count <= '0;
      sample_total  <= '0;
      running_sum   <= '0;
    end else begin
      r0_valid     <= item_take || (r0_valid && !s1_free);
      s1_valid     <= r0_fire || (s1_valid && !out_free);
      result_valid <= s1_fire || (result_valid && !result_ready);
      if (s1_fire) begin
        case (s1_action)
          ihb_pkg::ACT_COUNT: begin
            bin_valid[s1_addr] <= 1'b1;
            largest_count      <= largest_next;
            sample_total       <= total_next;
            running_sum        <= sum_next;
          end
          ihb_pkg::ACT_CLEAR: begin
            bin_valid     <= '0;
            largest_count <= '0;
            sample_total  <= '0;
            running_sum   <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (item_take) begin
      r0_item <= item;
    end
    if (r0_fire) begin
      s1_action   <= r0_item.action;
      s1_addr     <= r0_addr;
      s1_sel      <= r0_sel;
      s1_in_range <= r0_in_range;
      s1_sample   <= r0_item.sample_value;
    end
    if (s1_fire) begin
      result <= result_next;
    end
  end

  // bin count store
  always_ff @(posedge clk) begin
    if (s1_fire && (s1_action == ihb_pkg::ACT_COUNT)) begin
      bin_mem[s1_addr] <= inc;
    end
  end

  always_ff @(posedge clk) begin
    if (r0_fire) begin
      s1_rdata <= fwd ? inc : bin_mem[r0_addr];
    end
  end

endmodule

### hdl/ihb_checker.sv
// Port-level checks for the intensity histogram binner, with its bind.
module ihb_checker #(
  parameter int COUNT_BITS = ihb_pkg::COUNT_BITS_DEF
) (
  input logic             clk,
  input logic             rst,
  input logic             item_ready,
  input logic             result_valid,
  input logic             result_ready,
  input ihb_pkg::result_t result
);

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // input backs up only behind a stalled output
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid && !result_ready)
    else $error("item_ready low without output stall");

  // no bin count exceeds the running maximum
  a_bin_le_max: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (COUNT_BITS > 32) || (result.bin_count <= result.max_count))
    else $error("bin count above max count");

  // the maximum never exceeds the number of samples
  a_max_le_samples: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (COUNT_BITS > 32) || (result.max_count <= result.samples_seen))
    else $error("max count above samples seen");

endmodule

bind intensity_histogram_binner ihb_checker #(.COUNT_BITS(COUNT_BITS)) u_ihb_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
